// ----- sv/wfc_pkg.sv -----
// Package for the word frequency counter: sizing defaults, separator codes,
// the controller state type and the separator test.
// No dependencies; imported by word_frequency_counter_unit, wfc_checker and tb_top.
`default_nettype none

package wfc_pkg;

    // Default sizing of the word table and of one word
    localparam int MAX_WORDS_DEF    = 256;
    localparam int MAX_WORD_LEN_DEF = 32;

    // Result field widths
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Byte codes that close a word
    localparam logic [7:0] SEP_SPACE  = 8'h20;
    localparam logic [7:0] SEP_COMMA  = 8'h2C;
    localparam logic [7:0] SEP_PERIOD = 8'h2E;
    localparam logic [7:0] SEP_EXCL   = 8'h21;
    localparam logic [7:0] SEP_HYPHEN = 8'h2D;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_COPY,
        ST_EMIT
    } wfc_state_t;

    // True for a byte that ends the pending word
    function automatic logic is_sep(input logic [7:0] c);
        return (c == SEP_SPACE) || (c == SEP_COMMA) || (c == SEP_PERIOD) ||
               (c == SEP_EXCL) || (c == SEP_HYPHEN);
    endfunction

endpackage

`default_nettype wire

// ----- sv/wfc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for every store of the word frequency counter.
`default_nettype none

module wfc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/word_frequency_counter_unit.sv -----
// Word frequency counter top level: byte gathering, table search, insert and
// count update around three RAMs. Depends on wfc_pkg and wfc_ram.
//
//   Channel   Direction  Word fields
//   s_*       in         tdata = ch; tlast = end_of_line
//   m_*       out        tdata = word_index, word_count; tuser = new_word,
//                        table_full, truncated; tlast = line_end
//
// A byte that does not close a word leaves the block ready for the next byte.
// A closing byte is accepted; the search then visits each table entry in turn,
// runs past the last entry when no entry matches, compares byte by byte against
// each entry of equal length (up to and including the first byte that differs),
// copies the word in when it is inserted, and loads the result register.
// The table search is the limit: one entry info read per cycle, one byte pair
// per cycle while comparing or copying.
// aresetn (synchronous, active low) empties the table and the pending word.
// A result waiting on m_tready holds the next closing word in the last step only.
`default_nettype none

module word_frequency_counter_unit #(
    parameter int MAX_WORDS    = wfc_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // end_of_line
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] word_index, [23:8] word_count
    output logic [2:0]       m_tuser,   // [0] new_word, [1] table_full, [2] truncated
    output logic             m_tlast    // line_end
);
    import wfc_pkg::*;

    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int DIST_W  = $clog2(MAX_WORDS + 1);
    localparam int CUR_AW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int INFO_AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int STORE_D = MAX_WORDS * MAX_WORD_LEN;
    localparam int SA_W    = (STORE_D > 1) ? $clog2(STORE_D) : 1;
    localparam int INFO_W  = LEN_W + COUNT_W;

    // Control state
    wfc_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              cut_reg, cut_next;
    logic              eol_reg, eol_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [DIST_W-1:0] idx_reg, idx_next;
    logic [SA_W-1:0]   base_reg, base_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;

    // Pending result
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               new_reg, new_next;
    logic               full_reg, full_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] m_index_reg, m_index_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic [2:0]         m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    // RAM ports
    logic              cur_we;
    logic [CUR_AW-1:0] cur_waddr, cur_raddr;
    logic [7:0]        cur_rdata;
    logic              store_we;
    logic [SA_W-1:0]   store_waddr, store_raddr;
    logic [7:0]        store_rdata;
    logic              info_we;
    logic [INFO_AW-1:0] info_waddr, info_raddr;
    logic [INFO_W-1:0] info_wdata, info_rdata;

    logic               s_acc;
    logic               closing;
    logic               out_free;
    logic               search_end;
    logic               tbl_full;
    logic               len_hit;
    logic               byte_hit;
    logic               last_pos;
    logic [LEN_W-1:0]   info_len;
    logic [COUNT_W-1:0] info_cnt;
    logic [COUNT_W-1:0] cnt_inc;

    assign s_acc      = s_tvalid && s_tready;
    assign closing    = s_tlast || is_sep(s_tdata);
    assign out_free   = !m_valid_reg || m_tready;
    assign search_end = (idx_reg == dist_reg);
    assign tbl_full   = (dist_reg == DIST_W'(MAX_WORDS));
    assign info_len   = info_rdata[INFO_W-1:COUNT_W];
    assign info_cnt   = info_rdata[COUNT_W-1:0];
    assign len_hit    = (info_len == len_reg);
    assign byte_hit   = (store_rdata == cur_rdata);
    assign last_pos   = ((pos_reg + LEN_W'(1)) == len_reg);
    assign cnt_inc    = (info_cnt != COUNT_MAX) ? info_cnt + COUNT_W'(1) : info_cnt;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && closing && (len_reg != '0)) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_end) begin
                    state_next = tbl_full ? ST_EMIT : ST_COPY;
                end else if (len_hit) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!byte_hit) begin
                    state_next = ST_SEARCH;
                end else if (last_pos) begin
                    state_next = ST_EMIT;
                end
            end
            ST_COPY: begin
                if (last_pos) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs of the controller
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        len_next     = len_reg;
        cut_next     = cut_reg;
        eol_next     = eol_reg;
        dist_next    = dist_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        new_next     = new_reg;
        full_next    = full_reg;
        cur_we       = 1'b0;
        cur_waddr    = len_reg[CUR_AW-1:0];
        store_we     = 1'b0;
        store_waddr  = base_reg + SA_W'(pos_reg);
        info_we      = 1'b0;
        info_waddr   = idx_reg[INFO_AW-1:0];
        info_wdata   = {len_reg, cnt_inc};
        m_valid_next = m_valid_reg && !m_tready;
        m_index_next = m_index_reg;
        m_count_next = m_count_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                idx_next  = '0;
                base_next = '0;
                pos_next  = '0;
                if (s_acc) begin
                    if (closing) begin
                        eol_next = s_tlast;
                        if (len_reg == '0) begin
                            // Empty token: nothing to report
                            cut_next = 1'b0;
                            if (s_tlast) begin
                                dist_next = '0;
                            end
                        end
                    end else if (len_reg != LEN_W'(MAX_WORD_LEN)) begin
                        cur_we   = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end else begin
                        cut_next = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                pos_next = '0;
                if (search_end) begin
                    if (tbl_full) begin
                        // No room: drop the word
                        idx_next  = '0;
                        cnt_next  = '0;
                        new_next  = 1'b0;
                        full_next = 1'b1;
                    end
                end else if (!len_hit) begin
                    idx_next  = idx_reg + DIST_W'(1);
                    base_next = base_reg + SA_W'(MAX_WORD_LEN);
                end
            end
            ST_CMP: begin
                if (!byte_hit) begin
                    pos_next  = '0;
                    idx_next  = idx_reg + DIST_W'(1);
                    base_next = base_reg + SA_W'(MAX_WORD_LEN);
                end else if (last_pos) begin
                    // Found: bump the count in place
                    info_we   = 1'b1;
                    cnt_next  = cnt_inc;
                    new_next  = 1'b0;
                    full_next = 1'b0;
                end else begin
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
            ST_COPY: begin
                store_we = 1'b1;
                pos_next = pos_reg + LEN_W'(1);
                if (last_pos) begin
                    info_we    = 1'b1;
                    info_wdata = {len_reg, COUNT_W'(1)};
                    dist_next  = dist_reg + DIST_W'(1);
                    cnt_next   = COUNT_W'(1);
                    new_next   = 1'b1;
                    full_next  = 1'b0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = INDEX_W'(idx_reg);
                    m_count_next = cnt_reg;
                    m_user_next  = {cut_reg, full_reg, new_reg};
                    m_last_next  = eol_reg;
                    len_next     = '0;
                    cut_next     = 1'b0;
                    if (eol_reg) begin
                        dist_next = '0;
                    end
                end
            end
            default: ;
        endcase

        // Reads are addressed from the next-state values so that the registered read data matches the registers
        cur_raddr   = pos_next[CUR_AW-1:0];
        store_raddr = base_next + SA_W'(pos_next);
        info_raddr  = idx_next[INFO_AW-1:0];
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cut_reg     <= 1'b0;
            dist_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cut_reg     <= cut_next;
            dist_reg    <= dist_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        eol_reg     <= eol_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        new_reg     <= new_next;
        full_reg    <= full_next;
        m_index_reg <= m_index_next;
        m_count_reg <= m_count_next;
        m_user_reg  <= m_user_next;
        m_last_reg  <= m_last_next;
    end

    // Pending word bytes
    wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN), .ADDR_W(CUR_AW)) u_cur_ram (
        .clk     (aclk),
        .wr_en   (cur_we),
        .wr_addr (cur_waddr),
        .wr_data (s_tdata),
        .rd_addr (cur_raddr),
        .rd_data (cur_rdata)
    );

    // Bytes of every table word, one row of MAX_WORD_LEN per entry
    wfc_ram #(.WIDTH(8), .DEPTH(STORE_D), .ADDR_W(SA_W)) u_store_ram (
        .clk     (aclk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (cur_rdata),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    // Length and count of every table word
    wfc_ram #(.WIDTH(INFO_W), .DEPTH(MAX_WORDS), .ADDR_W(INFO_AW)) u_info_ram (
        .clk     (aclk),
        .wr_en   (info_we),
        .wr_addr (info_waddr),
        .wr_data (info_wdata),
        .rd_addr (info_raddr),
        .rd_data (info_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_index_reg};
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- sv/wfc_checker.sv -----
// Port-level checks for the word frequency counter, bound to the top level.
// Depends on wfc_pkg and word_frequency_counter_unit.
`default_nettype none

module wfc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import wfc_pkg::*;

    // A stalled result word holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result word changed while stalled");

    // No result straight after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A newly inserted word always reports a count of one
    a_new_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[23:8] == 16'd1) && !m_tuser[1])
        else $error("new word with count other than one");

    // A dropped word reports index and count zero
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[23:0] == 24'd0))
        else $error("dropped word with non-zero index or count");

    // After a plain word byte the block is ready again in the next cycle
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && !is_sep(s_tdata) |=> s_tready)
        else $error("not ready after a word byte");

endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for word_frequency_counter_unit: streams text bytes,
// predicts every token result and compares it on the m_* channel.
// Depends on wfc_pkg and the block's RTL only.
`default_nettype none

module tb_top;
    import wfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = MAX_WORDS_DEF;
    localparam int TOKEN_MAX  = MAX_WORD_LEN_DEF;
    localparam int VOCAB_N    = 12;
    // Worst closing byte: every entry visited and compared over almost the full
    // token length, then a copy, plus the longest stall and gap on both sides.
    localparam int QUIET_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPEAT_N = 100;

    // One expected result, one field per output field
    typedef struct packed {
        logic [7:0]  slot;
        logic [15:0] hits;
        logic        is_new;
        logic        is_full;
        logic        is_cut;
        logic        at_eol;
    } word_result_t;

    typedef logic [7:0] text_t [$];

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Shadow copy of the block's token and table state
    logic [7:0]  pend_bytes [TOKEN_MAX];
    int unsigned pend_len;
    bit          pend_cut;
    logic [7:0]  tbl_bytes [TABLE_SIZE][TOKEN_MAX];
    int unsigned tbl_len [TABLE_SIZE];
    logic [15:0] tbl_cnt [TABLE_SIZE];
    int unsigned tbl_used;

    word_result_t expected_words [$];
    word_result_t due;
    text_t        vocab [VOCAB_N];
    text_t        token;

    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    logic        ready_next;
    bit          source_gaps;
    bit          sink_stalls;

    word_frequency_counter_unit #(
        .MAX_WORDS   (TABLE_SIZE),
        .MAX_WORD_LEN(TOKEN_MAX)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Bytes that end the pending token
    function automatic bit is_delim(input logic [7:0] c);
        return c == SEP_SPACE || c == SEP_COMMA || c == SEP_PERIOD ||
               c == SEP_EXCL || c == SEP_HYPHEN;
    endfunction

    // Closes the pending token, if any, and queues the result it causes
    function automatic void close_token(input bit at_eol);
        word_result_t r;
        int unsigned  slot;
        bit           hit;
        bit           same;
        if (pend_len == 0) return;
        hit  = 1'b0;
        slot = 0;
        for (int unsigned i = 0; i < tbl_used && !hit; i++) begin
            if (tbl_len[i] == pend_len) begin
                same = 1'b1;
                for (int unsigned j = 0; j < pend_len; j++)
                    if (tbl_bytes[i][j] !== pend_bytes[j]) same = 1'b0;
                if (same) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
        end
        r = '0;
        if (hit) begin
            if (tbl_cnt[slot] != COUNT_MAX) tbl_cnt[slot] = tbl_cnt[slot] + 16'd1;
            r.slot = slot[7:0];
            r.hits = tbl_cnt[slot];
        end else if (tbl_used < TABLE_SIZE) begin
            for (int unsigned j = 0; j < pend_len; j++) tbl_bytes[tbl_used][j] = pend_bytes[j];
            tbl_len[tbl_used] = pend_len;
            tbl_cnt[tbl_used] = 16'd1;
            r.slot   = tbl_used[7:0];
            r.hits   = 16'd1;
            r.is_new = 1'b1;
            tbl_used++;
        end else begin
            r.is_full = 1'b1;
        end
        r.is_cut = pend_cut;
        r.at_eol = at_eol;
        expected_words.push_back(r);
        pend_len = 0;
        pend_cut = 1'b0;
    endfunction

    // Advances the shadow state by one accepted byte
    function automatic void count_byte(input logic [7:0] c, input logic eol);
        if (eol) begin
            close_token(1'b1);
            tbl_used = 0;
        end else if (is_delim(c)) begin
            close_token(1'b0);
        end else if (pend_len < TOKEN_MAX) begin
            pend_bytes[pend_len] = c;
            pend_len++;
        end else begin
            pend_cut = 1'b1;
        end
    endfunction

    function automatic logic [7:0] random_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_delim(b));
        return b;
    endfunction

    function automatic logic [7:0] random_delim();
        case ($urandom_range(0, 4))
            0: return SEP_SPACE;
            1: return SEP_COMMA;
            2: return SEP_PERIOD;
            3: return SEP_EXCL;
            default: return SEP_HYPHEN;
        endcase
    endfunction

    // Sends one byte, with an optional random gap, and predicts its effect
    task automatic send_byte(input logic [7:0] c, input logic eol);
        int unsigned gap;
        @(negedge aclk);
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        bytes_sent++;
        count_byte(c, eol);
    endtask

    task automatic send_token(input text_t t);
        foreach (t[k]) send_byte(t[k], 1'b0);
    endtask

    // Holds the source back until every queued result has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Sink: random stall bursts while enabled, ready otherwise
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    // Result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata, 0);
            end else begin
                due = expected_words.pop_front();
                if (m_tdata[7:0] !== due.slot) report_mismatch("word_index", m_tdata[7:0], due.slot);
                if (m_tdata[23:8] !== due.hits)
                    report_mismatch("word_count", m_tdata[23:8], due.hits);
                if (m_tuser[0] !== due.is_new) report_mismatch("new_word", m_tuser[0], due.is_new);
                if (m_tuser[1] !== due.is_full)
                    report_mismatch("table_full", m_tuser[1], due.is_full);
                if (m_tuser[2] !== due.is_cut) report_mismatch("truncated", m_tuser[2], due.is_cut);
                if (m_tlast !== due.at_eol) report_mismatch("line_end", m_tlast, due.at_eol);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("word_frequency_counter_unit regression: fail");
            $finish;
        end
    end

    // Byte extremes, every delimiter, empty tokens, case and line ends
    task automatic test_directed();
        send_byte(SEP_SPACE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SEP_COMMA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SEP_PERIOD, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(SEP_EXCL, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(SEP_HYPHEN, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(SEP_SPACE, 1'b0);
        send_byte(SEP_HYPHEN, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h41, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(SEP_COMMA, 1'b0);
        wait_drained();
        send_byte(8'h42, 1'b0);
        send_byte(SEP_SPACE, 1'b1);
    endtask

    // Tokens around the length limit, truncated ones matching their prefix
    task automatic test_long_tokens();
        for (int i = 0; i < TOKEN_MAX + 1; i++) send_byte(8'h30 + 8'(i), 1'b0);
        send_byte(SEP_SPACE, 1'b0);
        for (int i = 0; i < TOKEN_MAX; i++) send_byte(8'h30 + 8'(i), 1'b0);
        send_byte(SEP_COMMA, 1'b0);
        for (int i = 0; i < TOKEN_MAX - 1; i++) send_byte(8'h30 + 8'(i), 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(SEP_PERIOD, 1'b0);
        for (int i = 0; i < TOKEN_MAX + 8; i++) send_byte(8'h30 + 8'(i), 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Fills every table entry, then overflows it, also on a line end
    task automatic test_table_full();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            send_byte(8'h41 + 8'(i % 16), 1'b0);
            send_byte(8'h61 + 8'(i / 16), 1'b0);
            send_byte(random_delim(), 1'b0);
        end
        send_byte(8'h7A, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(SEP_SPACE, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(SEP_COMMA, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'h7A, 1'b1);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(SEP_EXCL, 1'b1);
    endtask

    // One token repeated back to back so that its count climbs steadily
    task automatic test_repeated_token();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        for (int i = 0; i < REPEAT_N; i++) begin
            send_byte(8'h71, 1'b0);
            send_byte(SEP_SPACE, 1'b0);
        end
        send_byte(8'h71, 1'b1);
    endtask

    // Lines of tokens drawn mostly from a small vocabulary, with noise bytes,
    // empty tokens, fresh and over-long tokens
    task automatic test_random_text(input int unsigned n_items, input bit with_idle);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        source_gaps = with_idle;
        sink_stalls = with_idle;
        // The first two entries share a 32-byte prefix; one of them is too long
        vocab[0] = {};
        for (int i = 0; i < TOKEN_MAX + 4; i++) vocab[0].push_back(random_text_byte());
        vocab[1] = vocab[0][0:TOKEN_MAX-1];
        for (int v = 2; v < VOCAB_N; v++) begin
            vocab[v] = {};
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) vocab[v].push_back(random_text_byte());
        end
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    token = vocab[$urandom_range(0, VOCAB_N - 1)];
                end else begin
                    if (pick < 93) len = $urandom_range(1, 10);
                    else if (pick < 97) len = $urandom_range(TOKEN_MAX + 1, TOKEN_MAX + 8);
                    else len = TOKEN_MAX;
                    token = {};
                    for (int i = 0; i < len; i++) token.push_back(random_text_byte());
                end
                send_token(token);
                if ($urandom_range(0, 9) == 0) send_byte(random_delim(), 1'b0);
                if ($urandom_range(0, 99) < 10) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    if ($urandom_range(0, 9) == 0) wait_drained();
                end else begin
                    send_byte(random_delim(), 1'b0);
                end
            end
        end
    endtask

    // Sequence of tests and final verdict
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        pend_len    = 0;
        pend_cut    = 1'b0;
        tbl_used    = 0;
        error_count = 0;
        bytes_sent  = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_long_tokens();
        test_table_full();
        test_repeated_token();
        test_random_text(450, 1'b1);
        test_random_text(110, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("word_frequency_counter_unit regression: pass");
        end else begin
            if (expected_words.size() != 0)
                report_mismatch("results never delivered", expected_words.size(), 0);
            $display("word_frequency_counter_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/wfc_pkg.sv
sv/wfc_ram.sv
sv/word_frequency_counter_unit.sv
sv/wfc_checker.sv
tb/tb_top.sv
